[rtl/core/q4es_pkg.sv]
`timescale 1ns / 1ps

package q4es_pkg;

    localparam logic [63:0] INV_SQRT3_Q32 = 64'd2479700525;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] x3;
        logic signed [31:0] y3;
        logic signed [31:0] deriv_value;
    } in_t;

    typedef struct packed {
        logic [1:0]         row;
        logic [1:0]         column;
        logic signed [31:0] entry;
        logic               last;
        logic               degenerate;
    } out_t;

endpackage

[rtl/core/q4es_fifo.sv]
`timescale 1ns / 1ps

module q4es_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/q4es_front.sv]
`timescale 1ns / 1ps

module q4es_front #(
    parameter int DATA_WIDTH = 32
) (
    input  q4es_pkg::in_t            element,
    input  logic                     push,
    output logic                     full,
    input  logic                     q_full,
    output logic                     q_push,
    output logic [9*DATA_WIDTH-1:0]  q_data
);

    localparam int W = DATA_WIDTH;

    function automatic logic [W-1:0] sat_in(input logic signed [31:0] v);
        logic signed [64:0] e;
        logic signed [64:0] mx;
        logic signed [64:0] mn;
        e  = 65'(v);
        mx = (65'sd1 <<< (W - 1)) - 65'sd1;
        mn = -mx - 65'sd1;
        if (e > mx)
        begin
            e = mx;
        end
        else if (e < mn)
        begin
            e = mn;
        end
        return e[W-1:0];
    endfunction

    assign q_push = push && !q_full;
    assign full   = q_full;

    assign q_data[0*W +: W] = sat_in(element.x0);
    assign q_data[1*W +: W] = sat_in(element.y0);
    assign q_data[2*W +: W] = sat_in(element.x1);
    assign q_data[3*W +: W] = sat_in(element.y1);
    assign q_data[4*W +: W] = sat_in(element.x2);
    assign q_data[5*W +: W] = sat_in(element.y2);
    assign q_data[6*W +: W] = sat_in(element.x3);
    assign q_data[7*W +: W] = sat_in(element.y3);
    assign q_data[8*W +: W] = sat_in(element.deriv_value);

endmodule

[rtl/core/q4es_back.sv]
`timescale 1ns / 1ps

module q4es_back #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_empty,
    input  logic [9*DATA_WIDTH-1:0] in_data,
    output logic                    in_pop,
    input  logic                    out_full,
    output logic                    out_push,
    output q4es_pkg::out_t          out_data
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int QW  = 2 * W + F;
    localparam int DVW = W + F;
    localparam int CW  = $clog2(DVW);

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    localparam logic [1:0] KIND_NV = 2'd0;
    localparam logic [1:0] KIND_DX = 2'd1;
    localparam logic [1:0] KIND_DE = 2'd2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_JAC  = 4'd1;
    localparam logic [3:0] S_DET  = 4'd2;
    localparam logic [3:0] S_GRAD = 4'd3;
    localparam logic [3:0] S_AN   = 4'd4;
    localparam logic [3:0] S_ROW  = 4'd5;
    localparam logic [3:0] S_ENT  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic signed [127:0] INV_SQRT3_Q32_S = 128'(q4es_pkg::INV_SQRT3_Q32);

    function automatic logic signed [127:0] c_sat(input logic signed [127:0] a);
        logic signed [127:0] mx;
        logic signed [127:0] mn;
        mx = (128'sd1 <<< (W - 1)) - 128'sd1;
        mn = -mx - 128'sd1;
        if (a > mx)
        begin
            return mx;
        end
        if (a < mn)
        begin
            return mn;
        end
        return a;
    endfunction

    function automatic logic signed [127:0] c_neg(input logic signed [127:0] a);
        return c_sat(-a);
    endfunction

    function automatic logic signed [127:0] c_mul(input logic signed [127:0] a,
                                                  input logic signed [127:0] b);
        logic signed [127:0] ma;
        logic signed [127:0] mb;
        logic signed [127:0] q;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        q  = (ma * mb + (128'sd1 <<< (F - 1))) >>> F;
        return ((a < 0) != (b < 0)) ? c_sat(-q) : c_sat(q);
    endfunction

    function automatic logic [W-1:0] shape_val(input logic [1:0] kind,
                                               input logic [1:0] p,
                                               input logic [1:0] k);
        logic signed [127:0] one;
        logic signed [127:0] gv;
        logic signed [127:0] xi;
        logic signed [127:0] eta;
        logic signed [127:0] xm;
        logic signed [127:0] xp;
        logic signed [127:0] em;
        logic signed [127:0] ep;
        logic signed [127:0] v;
        one = c_sat(128'sd1 <<< F);
        gv  = c_sat((128'(INV_SQRT3_Q32_S) + (128'sd1 <<< (31 - F))) >>> (32 - F));
        xi  = p[1] ? gv : c_neg(gv);
        eta = p[0] ? gv : c_neg(gv);
        xm  = c_sat(one + c_neg(xi));
        xp  = c_sat(one + xi);
        em  = c_sat(one + c_neg(eta));
        ep  = c_sat(one + eta);
        v   = '0;
        if (kind == KIND_NV)
        begin
            unique case (k)
                2'd0: v = c_mul(xm, em) / 4;
                2'd1: v = c_mul(xp, em) / 4;
                2'd2: v = c_mul(xp, ep) / 4;
                default: v = c_mul(xm, ep) / 4;
            endcase
        end
        else if (kind == KIND_DX)
        begin
            unique case (k)
                2'd0: v = c_neg(em / 4);
                2'd1: v = em / 4;
                2'd2: v = ep / 4;
                default: v = c_neg(ep / 4);
            endcase
        end
        else
        begin
            unique case (k)
                2'd0: v = c_neg(xm / 4);
                2'd1: v = c_neg(xp / 4);
                2'd2: v = xp / 4;
                default: v = xm / 4;
            endcase
        end
        return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? MINV : MAXV;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sneg(input logic [W-1:0] a);
        return (a == MINV) ? MAXV : W'(-a);
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        return a[W-1] ? W'(-a) : a;
    endfunction

    function automatic logic [W-1:0] from_mag(input logic neg, input logic [QW-1:0] q);
        if (!neg)
        begin
            return (q > QW'(MAXV)) ? MAXV : q[W-1:0];
        end
        if (q > QW'(MAXV) + QW'(1))
        begin
            return MINV;
        end
        return W'(~q + QW'(1));
    endfunction

    function automatic logic [W-1:0] qmul(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [2*W-1:0] p;
        logic [2*W:0]   pr;
        p  = mag(a) * mag(b);
        pr = {1'b0, p} + ((2*W+1)'(1) << (F - 1));
        return from_mag(a[W-1] ^ b[W-1], QW'(pr >> F));
    endfunction

    function automatic logic signed [31:0] sat32(input logic [W-1:0] a);
        logic signed [64:0] e;
        e = 65'(signed'(a));
        if (e > 65'sd2147483647)
        begin
            e = 65'sd2147483647;
        end
        else if (e < -65'sd2147483648)
        begin
            e = -65'sd2147483648;
        end
        return e[31:0];
    endfunction

    logic [W-1:0] nv_tab [4][4];
    logic [W-1:0] dx_tab [4][4];
    logic [W-1:0] de_tab [4][4];

    for (genvar gp = 0; gp < 4; gp++)
    begin : g_pt
        for (genvar gk = 0; gk < 4; gk++)
        begin : g_k
            assign nv_tab[gp][gk] = shape_val(KIND_NV, 2'(gp), 2'(gk));
            assign dx_tab[gp][gk] = shape_val(KIND_DX, 2'(gp), 2'(gk));
            assign de_tab[gp][gk] = shape_val(KIND_DE, 2'(gp), 2'(gk));
        end
    end

    logic [3:0]    state_reg;
    logic [3:0]    state_next;
    logic [3:0]    idx_reg;
    logic [3:0]    idx_next;
    logic [1:0]    sub_reg;
    logic [1:0]    sub_next;
    logic [1:0]    pt_reg;
    logic [1:0]    pt_next;
    logic          ph_reg;
    logic          ph_next;
    logic [CW-1:0] dcnt_reg;
    logic [CW-1:0] dcnt_next;
    logic          degen_reg;
    logic          degen_next;

    logic [W-1:0]   xs_reg [4];
    logic [W-1:0]   ys_reg [4];
    logic [W-1:0]   der_reg;
    logic [W-1:0]   j_reg [4];
    logic [W-1:0]   px_reg [4];
    logic [W-1:0]   py_reg [4];
    logic [W-1:0]   acc_reg [16];
    logic [W-1:0]   t_reg;
    logic [W-1:0]   adet_reg;
    logic [W-1:0]   an_reg;
    logic [W-1:0]   pm_reg;
    logic [W-1:0]   qm_reg;
    logic [W-1:0]   prod_reg;
    logic [DVW-1:0] dv_reg;
    logic [W-1:0]   rem_reg;
    logic           dneg_reg;

    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic [W-1:0] det_w;
    logic [W-1:0] ssum_w;
    logic [W:0]   rem_sh;
    logic         qbit;
    logic [1:0]   k_w;
    logic [1:0]   n_w;

    assign k_w    = idx_reg[3:2];
    assign n_w    = idx_reg[1:0];
    assign det_w  = sadd(t_reg, sneg(prod_reg));
    assign ssum_w = sadd(t_reg, prod_reg);
    assign rem_sh = {rem_reg, dv_reg[DVW-1]};
    assign qbit   = (rem_sh >= {1'b0, adet_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_JAC:
            begin
                mul_a = idx_reg[1] ? de_tab[pt_reg][k_w] : dx_tab[pt_reg][k_w];
                mul_b = idx_reg[0] ? ys_reg[k_w] : xs_reg[k_w];
            end
            S_DET:
            begin
                mul_a = idx_reg[0] ? j_reg[1] : j_reg[0];
                mul_b = idx_reg[0] ? j_reg[2] : j_reg[3];
            end
            S_GRAD:
            begin
                unique case (n_w)
                    2'd0:
                    begin
                        mul_a = j_reg[3];
                        mul_b = dx_tab[pt_reg][k_w];
                    end
                    2'd1:
                    begin
                        mul_a = j_reg[1];
                        mul_b = de_tab[pt_reg][k_w];
                    end
                    2'd2:
                    begin
                        mul_a = j_reg[0];
                        mul_b = de_tab[pt_reg][k_w];
                    end
                    default:
                    begin
                        mul_a = j_reg[2];
                        mul_b = dx_tab[pt_reg][k_w];
                    end
                endcase
            end
            S_AN:
            begin
                mul_a = adet_reg;
                mul_b = der_reg;
            end
            S_ENT:
            begin
                unique case (sub_reg)
                    2'd0:
                    begin
                        mul_a = pm_reg;
                        mul_b = px_reg[n_w];
                    end
                    2'd1:
                    begin
                        mul_a = qm_reg;
                        mul_b = py_reg[n_w];
                    end
                    2'd2:
                    begin
                        mul_a = nv_tab[pt_reg][k_w];
                        mul_b = nv_tab[pt_reg][n_w];
                    end
                    default:
                    begin
                        mul_a = an_reg;
                        mul_b = t_reg;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sub_next   = sub_reg;
        pt_next    = pt_reg;
        ph_next    = ph_reg;
        dcnt_next  = dcnt_reg;
        degen_next = degen_reg;
        in_pop     = 1'b0;
        out_push   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!in_empty)
                begin
                    in_pop     = 1'b1;
                    state_next = S_JAC;
                    idx_next   = '0;
                    pt_next    = '0;
                    ph_next    = 1'b0;
                    degen_next = 1'b0;
                end
            end
            S_JAC:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 4'd15)
                    begin
                        state_next = S_DET;
                    end
                end
            end
            S_DET:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (!idx_reg[0])
                    begin
                        idx_next = 4'd1;
                    end
                    else if (det_w == '0)
                    begin
                        degen_next = 1'b1;
                        idx_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_GRAD;
                    end
                end
            end
            S_GRAD:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 4'd15)
                    begin
                        state_next = S_AN;
                    end
                end
            end
            S_AN:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                state_next = S_ENT;
                sub_next   = '0;
                ph_next    = 1'b0;
            end
            S_ENT:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    sub_next = sub_reg + 1'b1;
                    if (sub_reg == 2'd1)
                    begin
                        state_next = S_DIV;
                        dcnt_next  = '0;
                    end
                    else if (sub_reg == 2'd3)
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (idx_reg == 4'd15)
                        begin
                            if (pt_reg == 2'd3)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                pt_next    = pt_reg + 1'b1;
                                state_next = S_JAC;
                            end
                        end
                        else if (idx_reg[1:0] == 2'd3)
                        begin
                            state_next = S_ROW;
                        end
                    end
                end
            end
            S_DIV:
            begin
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == CW'(DVW - 1))
                begin
                    state_next = S_ENT;
                end
            end
            S_OUT:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 4'd15)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            sub_reg   <= '0;
            pt_reg    <= '0;
            ph_reg    <= 1'b0;
            dcnt_reg  <= '0;
            degen_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sub_reg   <= sub_next;
            pt_reg    <= pt_next;
            ph_reg    <= ph_next;
            dcnt_reg  <= dcnt_next;
            degen_reg <= degen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= qmul(mul_a, mul_b);
        unique case (state_reg)
            S_IDLE:
            begin
                if (!in_empty)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        xs_reg[i] <= in_data[(2*i)*W +: W];
                        ys_reg[i] <= in_data[(2*i+1)*W +: W];
                        j_reg[i]  <= '0;
                    end
                    der_reg <= in_data[8*W +: W];
                    for (int i = 0; i < 16; i++)
                    begin
                        acc_reg[i] <= '0;
                    end
                end
            end
            S_JAC:
            begin
                if (ph_reg)
                begin
                    j_reg[n_w] <= sadd(j_reg[n_w], prod_reg);
                end
            end
            S_DET:
            begin
                if (ph_reg)
                begin
                    if (!idx_reg[0])
                    begin
                        t_reg <= prod_reg;
                    end
                    else
                    begin
                        adet_reg <= det_w[W-1] ? sneg(det_w) : det_w;
                    end
                end
            end
            S_GRAD:
            begin
                if (ph_reg)
                begin
                    unique case (n_w)
                        2'd0: t_reg <= prod_reg;
                        2'd1: px_reg[k_w] <= det_w;
                        2'd2: t_reg <= prod_reg;
                        default: py_reg[k_w] <= det_w;
                    endcase
                end
            end
            S_AN:
            begin
                if (ph_reg)
                begin
                    an_reg <= prod_reg;
                end
            end
            S_ROW:
            begin
                pm_reg <= px_reg[k_w];
                qm_reg <= py_reg[k_w];
            end
            S_ENT:
            begin
                if (ph_reg)
                begin
                    unique case (sub_reg)
                        2'd0: t_reg <= prod_reg;
                        2'd1:
                        begin
                            dv_reg   <= {mag(ssum_w), F'(0)};
                            rem_reg  <= '0;
                            dneg_reg <= ssum_w[W-1];
                        end
                        2'd2: t_reg <= prod_reg;
                        default:
                        begin
                            acc_reg[idx_reg] <= sadd(acc_reg[idx_reg],
                                sadd(from_mag(dneg_reg, QW'(dv_reg)), sneg(prod_reg)));
                            if (idx_reg == 4'd15)
                            begin
                                for (int i = 0; i < 4; i++)
                                begin
                                    j_reg[i] <= '0;
                                end
                            end
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                rem_reg <= qbit ? W'(rem_sh - {1'b0, adet_reg}) : rem_sh[W-1:0];
                dv_reg  <= {dv_reg[DVW-2:0], qbit};
            end
            default:
            begin
            end
        endcase
    end

    assign out_data.row        = idx_reg[3:2];
    assign out_data.column     = idx_reg[1:0];
    assign out_data.entry      = degen_reg ? 32'sd0 : sat32(acc_reg[idx_reg]);
    assign out_data.last       = (idx_reg == 4'd15);
    assign out_data.degenerate = degen_reg;

endmodule

[rtl/core/quad4_element_stiffness.sv]
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// element   push / full        q4es_pkg::in_t  (corners and source derivative)
// result    pop / empty        q4es_pkg::out_t (row, column, entry, last, degenerate)
//
// The time one element takes is set by the shared multiplier and the
// bit-per-cycle divider.
// A two-entry queue holds waiting elements; a two-entry queue holds results.
// Reset empties both queues and returns the sequencer to idle.
// A stalled result side holds the sequencer in its output phase.

module quad4_element_stiffness #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  q4es_pkg::in_t  element,
    input  logic           pop,
    output logic           empty,
    output q4es_pkg::out_t result
);

    localparam int IW = 9 * DATA_WIDTH;
    localparam int OW = $bits(q4es_pkg::out_t);

    logic           q_full;
    logic           q_push;
    logic [IW-1:0]  q_wdata;
    logic           q_empty;
    logic           q_pop;
    logic [IW-1:0]  q_rdata;
    logic           o_full;
    logic           o_push;
    q4es_pkg::out_t o_wdata;
    logic [OW-1:0]  o_rdata;

    q4es_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .element (element),
        .push    (push),
        .full    (full),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    q4es_fifo #(
        .WIDTH (IW),
        .DEPTH (2)
    ) u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    q4es_back #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (q_empty),
        .in_data  (q_rdata),
        .in_pop   (q_pop),
        .out_full (o_full),
        .out_push (o_push),
        .out_data (o_wdata)
    );

    q4es_fifo #(
        .WIDTH (OW),
        .DEPTH (2)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (o_push),
        .wr_data (o_wdata),
        .full    (o_full),
        .rd_en   (pop),
        .rd_data (o_rdata),
        .empty   (empty)
    );

    assign result = q4es_pkg::out_t'(o_rdata);

endmodule

[rtl/core/q4es_checker.sv]
`timescale 1ns / 1ps

module q4es_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           pop,
    input logic           empty,
    input q4es_pkg::out_t result
);

    logic [3:0] cnt_reg;
    logic       deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            deg_reg <= 1'b0;
        end
        else if (pop && !empty)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            deg_reg <= result.degenerate;
        end
    end

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.last == (cnt_reg == 4'd15)))
        else $error("last mark out of place");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ({result.row, result.column} == cnt_reg))
        else $error("row or column out of order");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.degenerate) |-> (result.entry == 32'sd0))
        else $error("degenerate element with nonzero entry");

    a_degen_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && cnt_reg != 4'd0) |-> (result.degenerate == deg_reg))
        else $error("degenerate flag changed within an element");

endmodule

bind quad4_element_stiffness q4es_checker u_q4es_checker (.*);
